// File: hdl/bpqe_pkg.sv
// shared constants, codes and types for the bounded priority queue
package bpqe_pkg;

   localparam int QUEUE_DEPTH  = 8;
   localparam int PAYLOAD_BITS = 32;
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic [2:0] ST_STORED  = 3'd0;
   localparam logic [2:0] ST_EVICTED = 3'd1;
   localparam logic [2:0] ST_DROPPED = 3'd2;
   localparam logic [2:0] ST_POPPED  = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   typedef logic [7:0]              priority_type;
   typedef logic [PAYLOAD_BITS-1:0] payload_type;
   typedef logic [CNT_BITS-1:0]     count_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic         pop;
      logic         push;
      logic         full;
      priority_type new_pri;
      payload_type  new_pay;
      priority_type last_pri;
   } cell_ctrl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic         valid;
      priority_type pri;
      payload_type  pay;
      logic         ins;
      logic         eq;
   } cell_link_type;

endpackage

// File: hdl/bpqe_if.sv
// valid/ready channel interfaces for request and response words
interface bpqe_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  priority_req;
   logic [31:0] payload;

   modport source (output valid, req_type, priority_req, payload, input ready);
   modport sink   (input valid, req_type, priority_req, payload, output ready);
endinterface

interface bpqe_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  out_priority;
   logic [31:0] out_payload;
   logic [3:0]  occupancy;

   modport source (output valid, status, out_priority, out_payload, occupancy, input ready);
   modport sink   (input valid, status, out_priority, out_payload, occupancy, output ready);
endinterface

// File: hdl/bpqe_cell.sv
// one slot of the sorted queue: holds an entry, shifts toward either neighbor
module bpqe_cell
   import bpqe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_link_type left,
   input  cell_link_type right,
   output cell_link_type self
);

   logic         valid_ff, valid_in;
   priority_type pri_ff, pri_in;
   payload_type  pay_ff, pay_in;
   logic         ins;
   logic         eq;
   logic         take_new;
   logic         take_left;

   assign ins = !valid_ff || (pri_ff < ctrl.new_pri);
   assign eq  = valid_ff && (pri_ff == ctrl.last_pri);

   // when full, shift down only inside the region that ends at the evicted entry
   assign take_new  = ctrl.push && ins && !left.ins;
   assign take_left = ctrl.push && left.ins && (!ctrl.full || !left.eq);

   always_comb begin
      valid_in = valid_ff;
      pri_in   = pri_ff;
      pay_in   = pay_ff;
      if (ctrl.pop) begin
         valid_in = right.valid;
         pri_in   = right.pri;
         pay_in   = right.pay;
      end else if (take_new) begin
         valid_in = 1'b1;
         pri_in   = ctrl.new_pri;
         pay_in   = ctrl.new_pay;
      end else if (take_left) begin
         valid_in = left.valid;
         pri_in   = left.pri;
         pay_in   = left.pay;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pri_ff <= pri_in;
      pay_ff <= pay_in;
   end

   assign self.valid = valid_ff;
   assign self.pri   = pri_ff;
   assign self.pay   = pay_ff;
   assign self.ins   = ins;
   assign self.eq    = eq;

endmodule

// File: hdl/bounded_priority_queue_evict_top.sv
// bounded priority queue: the response word is registered and shows in the cycle after a request is accepted
// throughput one request word per cycle, push or pop, whenever no response is held or the held one is taken
// the row of compare-and-shift cells updates in parallel, at the edge that registers the response word
// synchronous active-high reset empties the queue and drops any held response
// entry contents are not cleared; only per-cell valid flags are reset
module bounded_priority_queue_evict_top
   import bpqe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bpqe_req_if.sink    req,
   bpqe_rsp_if.source  rsp
);

   cell_link_type links [QUEUE_DEPTH];
   cell_ctrl_type ctrl;
   logic [QUEUE_DEPTH-1:0] valid_vec;

   count_type   count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   priority_type opri_ff, opri_in;
   logic [31:0] opay_ff, opay_in;

   logic accept;
   logic empty;
   logic full;
   logic drop;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == count_type'(QUEUE_DEPTH));
   assign drop      = full && !(req.priority_req > links[QUEUE_DEPTH-1].pri);

   assign ctrl.pop      = accept && (req.req_type == REQ_POP) && !empty;
   assign ctrl.push     = accept && (req.req_type == REQ_PUSH) && !drop;
   assign ctrl.full     = full;
   assign ctrl.new_pri  = req.priority_req;
   assign ctrl.new_pay  = payload_type'(req.payload);
   assign ctrl.last_pri = links[QUEUE_DEPTH-1].pri;

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         cell_link_type left_link;
         cell_link_type right_link;
         if (g == 0) begin : g_first
            assign left_link = '0;
         end else begin : g_mid_l
            assign left_link = links[g-1];
         end
         if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_link = '0;
         end else begin : g_mid_r
            assign right_link = links[g+1];
         end
         bpqe_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .left  (left_link),
            .right (right_link),
            .self  (links[g])
         );
         assign valid_vec[g] = links[g].valid;
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      opri_in   = opri_ff;
      opay_in   = opay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         opri_in      = '0;
         opay_in      = '0;
         if (req.req_type == REQ_POP) begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in = ST_POPPED;
               opri_in   = links[0].pri;
               opay_in   = 32'(links[0].pay);
               count_in  = count_ff - count_type'(1);
            end
         end else if (drop) begin
            status_in = ST_DROPPED;
         end else if (full) begin
            status_in = ST_EVICTED;
         end else begin
            status_in = ST_STORED;
            count_in  = count_ff + count_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      opri_ff   <= opri_in;
      opay_ff   <= opay_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.out_priority = opri_ff;
   assign rsp.out_payload  = opay_ff;
   assign rsp.occupancy    = 4'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(QUEUE_DEPTH))
      else $error("occupancy above depth");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("cell valid flags disagree with occupancy");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      links[0].valid == !empty)
      else $error("head cell valid does not match occupancy");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> count_ff == $past(count_ff) - count_type'(1))
      else $error("pop did not lower occupancy");

endmodule
